// File: design/bml_pkg.sv
// ----------------------------------------------------------------------------
// bml_pkg
// Shared types and constants for the toroidal traffic grid.
// ----------------------------------------------------------------------------
package bml_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int DIM_W    = 7;

    localparam logic [1:0] CELL_EMPTY = 2'd0;
    localparam logic [1:0] CELL_BLUE  = 2'd1;
    localparam logic [1:0] CELL_RED   = 2'd2;

    typedef logic [MAX_COLS-1:0][1:0] row_t;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_RED,
        ST_BPRE,
        ST_BFIRST,
        ST_BLUE
    } state_t;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

endpackage

// File: design/bml_traffic_grid_step.sv
// ----------------------------------------------------------------------------
// bml_traffic_grid_step
// Toroidal traffic grid, one row per memory word, row-wise step sequencer.
// ----------------------------------------------------------------------------
//  channel   signals                                         handshake
//  request   start, command, row_index, col_index, cell_value start & !busy
//  result    done, read_value, next_is_red                    done, one cycle
//  config    cfg_valid, cfg_index, cfg_data, cfg_ready        valid & ready
//
//  Write, read and unused commands read the row, then modify/write it in ST_ACCESS.
//  A red step runs ST_RED; a blue step runs ST_BPRE, ST_BFIRST, then ST_BLUE;
//  both go one row per cycle through the single-port-read row memory.
//  After reset all rows read as empty through per-row valid bits; no clear pass.
//  The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module bml_traffic_grid_step (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  command,
    input  logic [bml_pkg::ROW_W-1:0]   row_index,
    input  logic [bml_pkg::COL_W-1:0]   col_index,
    input  logic [1:0]                  cell_value,
    output logic                        done,
    output logic [1:0]                  read_value,
    output logic                        next_is_red,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [bml_pkg::DIM_W-1:0]   cfg_data
);

    bml_pkg::row_t mem [bml_pkg::MAX_ROWS];
    logic [bml_pkg::MAX_ROWS-1:0] valid_reg;

    bml_pkg::state_t state_reg, state_next;
    logic [bml_pkg::ROW_W-1:0] r_reg, r_next;
    bml_pkg::cmd_t cmd_reg;
    logic [bml_pkg::COL_W-1:0] col_reg;
    logic [1:0] val_reg;
    bml_pkg::row_t prev_reg, prev_next, cur_reg, cur_next, first_reg, first_next;
    bml_pkg::row_t rd_data_reg;
    logic rd_valid_reg;
    logic phase_reg, phase_next;
    logic [bml_pkg::DIM_W-1:0] rows_reg, cols_reg;
    logic done_reg, done_next;
    logic [1:0] rdval_reg, rdval_next;

    logic rd_en, we;
    logic [bml_pkg::ROW_W-1:0] rd_addr, wr_addr;
    bml_pkg::row_t wr_data, row_q, nb_row, calc_cur, calc_out;
    logic [bml_pkg::DIM_W-1:0] nr, nc, r_plus2;
    logic [bml_pkg::ROW_W-1:0] last_row;
    logic accept;

    assign nr = (rows_reg == '0) ? bml_pkg::DIM_W'(1) :
                (rows_reg > bml_pkg::DIM_W'(bml_pkg::MAX_ROWS)) ?
                bml_pkg::DIM_W'(bml_pkg::MAX_ROWS) : rows_reg;
    assign nc = (cols_reg == '0) ? bml_pkg::DIM_W'(1) :
                (cols_reg > bml_pkg::DIM_W'(bml_pkg::MAX_COLS)) ?
                bml_pkg::DIM_W'(bml_pkg::MAX_COLS) : cols_reg;
    logic [bml_pkg::DIM_W-1:0] nr_m1;
    assign nr_m1    = nr - 1'b1;
    assign last_row = nr_m1[bml_pkg::ROW_W-1:0];
    assign r_plus2  = bml_pkg::DIM_W'(r_reg) + bml_pkg::DIM_W'(2);

    assign busy      = (state_reg != bml_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done        = done_reg;
    assign read_value  = rdval_reg;
    assign next_is_red = phase_reg;

    assign row_q    = rd_valid_reg ? rd_data_reg : '0;
    assign nb_row   = (r_reg == last_row) ? first_reg : row_q;
    assign calc_cur = (state_reg == bml_pkg::ST_RED) ? row_q : cur_reg;

    bml_row_calc u_calc (
        .red_phase (phase_reg),
        .ncols     (nc),
        .prev_row  (prev_reg),
        .cur_row   (calc_cur),
        .next_row  (nb_row),
        .new_row   (calc_out)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bml_pkg::ST_IDLE:
                if (accept)
                begin
                    if (bml_pkg::cmd_t'(command) == bml_pkg::CMD_STEP)
                        state_next = phase_reg ? bml_pkg::ST_RED : bml_pkg::ST_BPRE;
                    else
                        state_next = bml_pkg::ST_ACCESS;
                end
            bml_pkg::ST_ACCESS: state_next = bml_pkg::ST_IDLE;
            bml_pkg::ST_RED:    if (r_reg == last_row) state_next = bml_pkg::ST_IDLE;
            bml_pkg::ST_BPRE:   state_next = bml_pkg::ST_BFIRST;
            bml_pkg::ST_BFIRST: state_next = bml_pkg::ST_BLUE;
            bml_pkg::ST_BLUE:   if (r_reg == last_row) state_next = bml_pkg::ST_IDLE;
            default:            state_next = bml_pkg::ST_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        rd_en      = 1'b0;
        rd_addr    = '0;
        we         = 1'b0;
        wr_addr    = r_reg;
        wr_data    = calc_out;
        r_next     = r_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        first_next = first_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        rdval_next = rdval_reg;
        case (state_reg)
            bml_pkg::ST_IDLE:
                if (accept)
                begin
                    rd_en = 1'b1;
                    if (bml_pkg::cmd_t'(command) == bml_pkg::CMD_STEP)
                    begin
                        rd_addr = phase_reg ? '0 : last_row;
                        r_next  = '0;
                    end
                    else
                    begin
                        rd_addr = row_index;
                        r_next  = row_index;
                    end
                end
            bml_pkg::ST_ACCESS:
            begin
                done_next  = 1'b1;
                rdval_next = (cmd_reg == bml_pkg::CMD_READ) ? row_q[col_reg] : bml_pkg::CELL_EMPTY;
                if (cmd_reg == bml_pkg::CMD_WRITE && val_reg != 2'd3)
                begin
                    we = 1'b1;
                    wr_data = row_q;
                    wr_data[col_reg] = val_reg;
                end
            end
            bml_pkg::ST_RED:
            begin
                we = 1'b1;
                if (r_reg == last_row)
                begin
                    done_next  = 1'b1;
                    rdval_next = bml_pkg::CELL_EMPTY;
                    phase_next = ~phase_reg;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = r_reg + 1'b1;
                    r_next  = r_reg + 1'b1;
                end
            end
            bml_pkg::ST_BPRE:
            begin
                prev_next = row_q;
                rd_en     = 1'b1;
                rd_addr   = '0;
            end
            bml_pkg::ST_BFIRST:
            begin
                cur_next   = row_q;
                first_next = row_q;
                r_next     = '0;
                if (last_row != '0)
                begin
                    rd_en   = 1'b1;
                    rd_addr = bml_pkg::ROW_W'(1);
                end
            end
            bml_pkg::ST_BLUE:
            begin
                we        = 1'b1;
                prev_next = cur_reg;
                cur_next  = nb_row;
                if (r_plus2 <= nr_m1)
                begin
                    rd_en   = 1'b1;
                    rd_addr = r_plus2[bml_pkg::ROW_W-1:0];
                end
                if (r_reg == last_row)
                begin
                    done_next  = 1'b1;
                    rdval_next = bml_pkg::CELL_EMPTY;
                    phase_next = ~phase_reg;
                end
                else
                    r_next = r_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bml_pkg::ST_IDLE;
            valid_reg <= '0;
            phase_reg <= 1'b0;
            rows_reg  <= bml_pkg::DIM_W'(bml_pkg::MAX_ROWS);
            cols_reg  <= bml_pkg::DIM_W'(bml_pkg::MAX_COLS);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
            if (we)
                valid_reg[wr_addr] <= 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == bml_pkg::CFG_ROWS)
                    rows_reg <= cfg_data;
                else
                    cols_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        first_reg <= first_next;
        rdval_reg <= rdval_next;
        if (accept)
        begin
            cmd_reg <= bml_pkg::cmd_t'(command);
            col_reg <= col_index;
            val_reg <= cell_value;
        end
    end

    // row memory
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

endmodule

// File: design/bml_row_calc.sv
// ----------------------------------------------------------------------------
// bml_row_calc
// New content of one grid row from the old row and, in the blue phase, its two neighbors.
// ----------------------------------------------------------------------------
module bml_row_calc (
    input  logic                       red_phase,
    input  logic [bml_pkg::DIM_W-1:0]  ncols,
    input  bml_pkg::row_t              prev_row,
    input  bml_pkg::row_t              cur_row,
    input  bml_pkg::row_t              next_row,
    output bml_pkg::row_t              new_row
);

    always_comb
    begin
        logic [bml_pkg::DIM_W-1:0] cidx;
        logic [bml_pkg::DIM_W-1:0] tc;
        logic [bml_pkg::DIM_W-1:0] pc;
        new_row = cur_row;
        for (int c = 0; c < bml_pkg::MAX_COLS; c++)
        begin
            cidx = bml_pkg::DIM_W'(c);
            tc   = (cidx + 1'b1 == ncols) ? '0 : cidx + 1'b1;
            pc   = (cidx == '0) ? ncols - 1'b1 : cidx - 1'b1;
            if (cidx < ncols)
            begin
                if (red_phase)
                begin
                    if (cur_row[c] == bml_pkg::CELL_RED &&
                        cur_row[tc[bml_pkg::COL_W-1:0]] == bml_pkg::CELL_EMPTY)
                        new_row[c] = bml_pkg::CELL_EMPTY;
                    else if (cur_row[c] == bml_pkg::CELL_EMPTY &&
                             cur_row[pc[bml_pkg::COL_W-1:0]] == bml_pkg::CELL_RED)
                        new_row[c] = bml_pkg::CELL_RED;
                end
                else
                begin
                    if (cur_row[c] == bml_pkg::CELL_BLUE && prev_row[c] == bml_pkg::CELL_EMPTY)
                        new_row[c] = bml_pkg::CELL_EMPTY;
                    else if (cur_row[c] == bml_pkg::CELL_EMPTY &&
                             next_row[c] == bml_pkg::CELL_BLUE)
                        new_row[c] = bml_pkg::CELL_BLUE;
                end
            end
        end
    end

endmodule
